// File: rtl/core/swpseg_pkg.sv
// Shared types, constants and the tangent table of the sweep object segmenter.
// Used by every module in rtl/core but swpseg_fifo; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package swpseg_pkg;

    // Field widths of the sample, result and configuration items.
    localparam int ANGLE_W    = 8;
    localparam int RANGE_W    = 12;
    localparam int DIST_W     = 10;
    localparam int NUM_W      = 8;
    localparam int OBJW_W     = 26;
    localparam int CORR_W     = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;

    // Defaults for the top level parameters.
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MAX_ANGLE_DEF   = 180;

    // Tangent format: signed, 8 integer bits and TAN_FRACTION_BITS fraction bits.
    localparam int TAN_FRACTION_BITS = 8;
    localparam int TAN_W             = 8 + TAN_FRACTION_BITS;
    localparam int TAN_MAG_W         = TAN_W - 1;

    // Reset values of the sweep state and of the registers.
    localparam int PREV_RESET   = 300;
    localparam int THRESH_RESET = 100;
    localparam int NEAR_RESET   = 120;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_ENABLED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CORRECTION   = 2'd3;

    typedef struct packed {
        logic [RANGE_W-1:0]       jump_threshold;
        logic [RANGE_W-1:0]       near_limit;
        logic                     correction_enabled;
        logic signed [CORR_W-1:0] width_correction;
    } cfg_t;

    // One closed object handed from the front end to the width unit.
    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] stop_angle;
        logic [DIST_W-1:0]  distance;
    } job_t;

    typedef struct packed {
        logic [NUM_W-1:0]         object_number;
        logic [ANGLE_W-1:0]       center_angle;
        logic [DIST_W-1:0]        object_distance;
        logic signed [OBJW_W-1:0] object_extent;
    } result_t;

    // tan(k degrees) in unsigned Q7.8 for k = 0..89, all entries non-negative.
    localparam logic [TAN_MAG_W-1:0] TAN_ROM [0:89] = '{
        15'd0,    15'd4,    15'd9,    15'd13,   15'd18,
        15'd22,   15'd27,   15'd31,   15'd36,   15'd41,
        15'd45,   15'd50,   15'd54,   15'd59,   15'd64,
        15'd69,   15'd73,   15'd78,   15'd83,   15'd88,
        15'd93,   15'd98,   15'd103,  15'd109,  15'd114,
        15'd119,  15'd125,  15'd130,  15'd136,  15'd142,
        15'd148,  15'd154,  15'd160,  15'd166,  15'd173,
        15'd179,  15'd186,  15'd193,  15'd200,  15'd207,
        15'd215,  15'd223,  15'd231,  15'd239,  15'd247,
        15'd256,  15'd265,  15'd275,  15'd284,  15'd294,
        15'd305,  15'd316,  15'd328,  15'd340,  15'd352,
        15'd366,  15'd380,  15'd394,  15'd410,  15'd426,
        15'd443,  15'd462,  15'd481,  15'd502,  15'd525,
        15'd549,  15'd575,  15'd603,  15'd634,  15'd667,
        15'd703,  15'd743,  15'd788,  15'd837,  15'd893,
        15'd955,  15'd1027, 15'd1109, 15'd1204, 15'd1317,
        15'd1452, 15'd1616, 15'd1822, 15'd2085, 15'd2436,
        15'd2926, 15'd3661, 15'd4885, 15'd7331, 15'd14666
    };

endpackage

`default_nettype wire

// File: rtl/core/swpseg_fifo.sv
// Small synchronous queue in registers, one write and one read per cycle.
// Generic; used for the object queue and the result queue. No package needed.
`timescale 1ns / 1ps
`default_nettype none

module swpseg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    output logic      [WIDTH-1:0]           rd_data,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

`default_nettype wire

// File: rtl/core/swpseg_front.sv
// Front end: takes samples, finds edges, tracks the open object and queues closed ones.
// Depends on swpseg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swpseg_front
    import swpseg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_ANGLE   = MAX_ANGLE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               first_of_sweep,
    input  wire logic [ANGLE_W-1:0] sweep_angle,
    input  wire logic [RANGE_W-1:0] range_sample,
    input  wire logic [DIST_W-1:0]  sonar_distance,
    input  wire logic               job_full,
    output logic                    job_push,
    output job_t                    job
);

    // Only the low SAMPLE_BITS of the range reading take part.
    localparam int SW = (SAMPLE_BITS < RANGE_W) ? SAMPLE_BITS : RANGE_W;
    localparam logic [SW-1:0] PREV_INIT = SW'(PREV_RESET % (1 << SAMPLE_BITS));

    logic [SW-1:0]      prev_reg;
    logic               inside_reg;
    logic [ANGLE_W-1:0] start_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [NUM_W-1:0]   count_reg;

    logic [SW-1:0]      base_prev;
    logic               base_inside;
    logic [ANGLE_W-1:0] base_start;
    logic [DIST_W-1:0]  base_dist;
    logic [NUM_W-1:0]   base_count;

    logic [SW-1:0]      sample;
    logic [SW-1:0]      diff;
    logic [ANGLE_W-1:0] angle;
    logic               accept, is_edge, opening, closing;

    assign accept = push && !full;
    assign full   = job_full;

    // A new sweep starts from the reset state before this sample is looked at.
    assign base_prev   = first_of_sweep ? PREV_INIT : prev_reg;
    assign base_inside = first_of_sweep ? 1'b0 : inside_reg;
    assign base_start  = first_of_sweep ? '0 : start_reg;
    assign base_dist   = first_of_sweep ? '0 : dist_reg;
    assign base_count  = first_of_sweep ? '0 : count_reg;

    assign sample = range_sample[SW-1:0];
    assign angle  = (sweep_angle > ANGLE_W'(MAX_ANGLE)) ? ANGLE_W'(MAX_ANGLE) : sweep_angle;
    assign diff   = (base_prev >= sample) ? base_prev - sample : sample - base_prev;

    assign is_edge = RANGE_W'(diff) >= cfg.jump_threshold;
    assign opening = is_edge && !base_inside && (RANGE_W'(sample) <= cfg.near_limit);
    assign closing = is_edge && base_inside;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= PREV_INIT;
            inside_reg <= 1'b0;
            start_reg  <= '0;
            dist_reg   <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            prev_reg   <= sample;
            inside_reg <= opening ? 1'b1 : (closing ? 1'b0 : base_inside);
            start_reg  <= opening ? angle : base_start;
            dist_reg   <= opening ? sonar_distance : base_dist;
            if (closing && (base_count != '1))
            begin
                count_reg <= base_count + 1'b1;
            end
            else
            begin
                count_reg <= base_count;
            end
        end
    end

    assign job_push         = accept && closing;
    assign job.number       = base_count;
    assign job.start_angle  = base_start;
    assign job.stop_angle   = angle;
    assign job.distance     = base_dist;

endmodule

`default_nettype wire

// File: rtl/core/swpseg_back.sv
// Width unit: tangent lookup, two multiplies and saturation over two register stages.
// Depends on swpseg_pkg; feeds the result queue and takes credit from its fill count.
`timescale 1ns / 1ps
`default_nettype none

module swpseg_back
    import swpseg_pkg::*;
#(
    parameter int OUT_DEPTH = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cfg_t                         cfg,
    input  wire logic                         job_empty,
    input  wire job_t                         job,
    output logic                              job_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                              res_push,
    output result_t                           res
);

    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int SPAN_W = ANGLE_W + 1;
    localparam int P1_W   = DIST_W + 1 + TAN_W;
    localparam int P2_W   = DIST_W + 1 + CORR_W;
    localparam int TOT_W  = P1_W + (16 - TAN_FRACTION_BITS) + 1;
    localparam int W_W    = TOT_W - 8;

    localparam logic signed [TAN_W-1:0] TAN_MAX = {1'b0, {(TAN_W-1){1'b1}}};
    localparam logic signed [TAN_W-1:0] TAN_MIN = {1'b1, {(TAN_W-1){1'b0}}};
    localparam logic signed [OBJW_W-1:0] OBJW_MAX = {1'b0, {(OBJW_W-1){1'b1}}};
    localparam logic signed [OBJW_W-1:0] OBJW_MIN = {1'b1, {(OBJW_W-1){1'b0}}};

    // Stage A: tangent of the span.
    logic                     a_valid_reg;
    logic signed [TAN_W-1:0]  a_tan_reg;
    logic [DIST_W-1:0]        a_dist_reg;
    logic [NUM_W-1:0]         a_num_reg;
    logic [ANGLE_W-1:0]       a_center_reg;

    // Stage B: products.
    logic                     b_valid_reg;
    logic signed [P1_W-1:0]   b_p1_reg;
    logic signed [P2_W-1:0]   b_p2_reg;
    logic [DIST_W-1:0]        b_dist_reg;
    logic [NUM_W-1:0]         b_num_reg;
    logic [ANGLE_W-1:0]       b_center_reg;

    logic signed [SPAN_W-1:0] span;
    logic [SPAN_W-1:0]        span_mag;
    logic [ANGLE_W-1:0]       r;
    logic [6:0]               rom_idx;
    logic [TAN_MAG_W-1:0]     mag;
    logic                     span_neg, flip;
    logic signed [TAN_W-1:0]  tan_val;
    logic [SPAN_W-1:0]        angle_sum;

    logic signed [TOT_W-1:0]  total;
    logic signed [W_W-1:0]    w_floor;
    logic signed [OBJW_W-1:0] w_sat;
    logic [CNT_W+1:0]         committed;

    // Each pop reserves a result queue slot for the whole trip through the stages.
    assign committed = (CNT_W+2)'(out_count) + (CNT_W+2)'(a_valid_reg)
                       + (CNT_W+2)'(b_valid_reg);
    assign job_pop   = !job_empty && (committed < (CNT_W+2)'(OUT_DEPTH));

    always_comb
    begin
        span     = $signed({1'b0, job.stop_angle}) - $signed({1'b0, job.start_angle});
        span_neg = span[SPAN_W-1];
        span_mag = span_neg ? SPAN_W'(-span) : SPAN_W'(span);
        // The span magnitude stays below 360, so one subtract gives the remainder.
        r        = (span_mag >= SPAN_W'(180)) ? ANGLE_W'(span_mag - SPAN_W'(180))
                                              : ANGLE_W'(span_mag);
        // A right angle bypasses the table, so its index is parked at zero.
        if (r < ANGLE_W'(90))
        begin
            rom_idx = r[6:0];
        end
        else if (r > ANGLE_W'(90))
        begin
            rom_idx = 7'(ANGLE_W'(180) - r);
        end
        else
        begin
            rom_idx = '0;
        end
        mag      = TAN_ROM[rom_idx];
        flip     = span_neg ^ (r > ANGLE_W'(90));
        if (r == ANGLE_W'(90))
        begin
            tan_val = span_neg ? TAN_MIN : TAN_MAX;
        end
        else if (flip)
        begin
            tan_val = -$signed({1'b0, mag});
        end
        else
        begin
            tan_val = $signed({1'b0, mag});
        end
        angle_sum = {1'b0, job.start_angle} + {1'b0, job.stop_angle};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= job_pop;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tan_reg    <= tan_val;
        a_dist_reg   <= job.distance;
        a_num_reg    <= job.number;
        a_center_reg <= angle_sum[SPAN_W-1:1];

        b_p1_reg     <= $signed({1'b0, a_dist_reg}) * a_tan_reg;
        b_p2_reg     <= $signed({1'b0, a_dist_reg}) * cfg.width_correction;
        b_dist_reg   <= a_dist_reg;
        b_num_reg    <= a_num_reg;
        b_center_reg <= a_center_reg;
    end

    always_comb
    begin
        total = TOT_W'(b_p1_reg) <<< (16 - TAN_FRACTION_BITS);
        if (cfg.correction_enabled)
        begin
            total = total - TOT_W'(b_p2_reg);
        end
        // Arithmetic shift is the floor of the division by 256.
        w_floor = W_W'(total >>> 8);
        if (w_floor > W_W'(OBJW_MAX))
        begin
            w_sat = OBJW_MAX;
        end
        else if (w_floor < W_W'(OBJW_MIN))
        begin
            w_sat = OBJW_MIN;
        end
        else
        begin
            w_sat = OBJW_W'(w_floor);
        end
    end

    assign res_push            = b_valid_reg;
    assign res.object_number   = b_num_reg;
    assign res.center_angle    = b_center_reg;
    assign res.object_distance = b_dist_reg;
    assign res.object_extent   = w_sat;

endmodule

`default_nettype wire

// File: rtl/core/sweep_object_segmenter.sv
// Top level of the sweep object segmenter: configuration registers and queues.
// Depends on swpseg_pkg, swpseg_front, swpseg_back and swpseg_fifo.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one sweep sample per clock cycle and emits one record for
// every object that closes. The front end classifies each sample in the cycle
// it is accepted, so samples follow back to back; a closed object waits in a
// two-entry queue, then passes the tangent lookup stage and the multiply stage
// and lands in a four-entry result queue. The width unit also takes one object
// per cycle, so full is raised only while the result side is stalled and both
// queues have filled. Configuration is written through cfg_write, cfg_index
// and cfg_data, and must be changed only while no object is in flight. No
// clearing pass follows reset.
module sweep_object_segmenter
    import swpseg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_ANGLE   = MAX_ANGLE_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic                     first_of_sweep,
    input  wire logic [ANGLE_W-1:0]       sweep_angle,
    input  wire logic [RANGE_W-1:0]       range_sample,
    input  wire logic [DIST_W-1:0]        sonar_distance,
    output logic                          empty,
    input  wire logic                     pop,
    output logic [NUM_W-1:0]              object_number,
    output logic [ANGLE_W-1:0]            center_angle,
    output logic [DIST_W-1:0]             object_distance,
    output logic signed [OBJW_W-1:0]      object_extent
);

    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    cfg_t                 cfg_reg;
    job_t                 front_job, back_job;
    logic                 job_push, job_pop, job_full, job_empty;
    result_t              res_in, res_out;
    logic                 res_push;
    logic [OUT_CNT_W-1:0] out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jump_threshold     <= RANGE_W'(THRESH_RESET);
            cfg_reg.near_limit         <= RANGE_W'(NEAR_RESET);
            cfg_reg.correction_enabled <= 1'b0;
            cfg_reg.width_correction   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_JUMP_THRESHOLD:     cfg_reg.jump_threshold     <= cfg_data[RANGE_W-1:0];
                REG_NEAR_LIMIT:         cfg_reg.near_limit         <= cfg_data[RANGE_W-1:0];
                REG_CORRECTION_ENABLED: cfg_reg.correction_enabled <= cfg_data[0];
                REG_WIDTH_CORRECTION:   cfg_reg.width_correction   <= $signed(cfg_data[CORR_W-1:0]);
                default:                ;
            endcase
        end
    end

    swpseg_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_ANGLE   (MAX_ANGLE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .push           (push),
        .full           (full),
        .first_of_sweep (first_of_sweep),
        .sweep_angle    (sweep_angle),
        .range_sample   (range_sample),
        .sonar_distance (sonar_distance),
        .job_full       (job_full),
        .job_push       (job_push),
        .job            (front_job)
    );

    swpseg_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (front_job),
        .rd_en   (job_pop),
        .rd_data (back_job),
        .full    (job_full),
        .empty   (job_empty),
        .count   ()
    );

    swpseg_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job       (back_job),
        .job_pop   (job_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (res_in)
    );

    swpseg_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (),
        .empty   (empty),
        .count   (out_count)
    );

    assign object_number   = res_out.object_number;
    assign center_angle    = res_out.center_angle;
    assign object_distance = res_out.object_distance;
    assign object_extent   = res_out.object_extent;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for sweep_object_segmenter: queued sweep samples, a
// predictor of the records of the segmenter and an in-order check of each one.
// Depends on swpseg_pkg and the RTL in rtl/core.
`timescale 1ns / 1ps

module tb_top;
    import swpseg_pkg::*;

    // Nothing moves for at most a long receiver hold plus a sender gap; the
    // limit is that worst case taken several times over.
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;

    localparam longint unsigned SIN_ONE_DEG = 64'd18739379;
    localparam longint unsigned COS_ONE_DEG = 64'd1073578288;
    localparam longint TAN_HI   = (64'sd1 <<< (7 + TAN_FRACTION_BITS)) - 64'sd1;
    localparam longint TAN_LO   = -(64'sd1 <<< (7 + TAN_FRACTION_BITS));
    localparam longint WIDTH_HI = 64'sd33554431;
    localparam longint WIDTH_LO = -64'sd33554432;
    localparam int ANGLE_CAP  = MAX_ANGLE_DEF;
    localparam int RANGE_TOP  = (1 << RANGE_W) - 1;
    localparam int DIST_TOP   = (1 << DIST_W) - 1;
    localparam int LEVEL_MASK = (1 << SAMPLE_BITS_DEF) - 1;

    typedef struct {
        logic               restart;
        logic [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0] level;
        logic [DIST_W-1:0]  sonar;
    } sample_t;

    typedef enum {POP_ALWAYS, POP_COIN, POP_TRICKLE, POP_PAUSE} pop_mode_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  push           = 1'b0;
    wire                   full;
    logic                  first_of_sweep = 1'b0;
    logic [ANGLE_W-1:0]    sweep_angle    = '0;
    logic [RANGE_W-1:0]    range_sample   = '0;
    logic [DIST_W-1:0]     sonar_distance = '0;
    wire                   empty;
    logic                  pop            = 1'b0;
    wire [NUM_W-1:0]       object_number;
    wire [ANGLE_W-1:0]     center_angle;
    wire [DIST_W-1:0]      object_distance;
    wire signed [OBJW_W-1:0] object_extent;

    sweep_object_segmenter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .first_of_sweep  (first_of_sweep),
        .sweep_angle     (sweep_angle),
        .range_sample    (range_sample),
        .sonar_distance  (sonar_distance),
        .empty           (empty),
        .pop             (pop),
        .object_number   (object_number),
        .center_angle    (center_angle),
        .object_distance (object_distance),
        .object_extent   (object_extent)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow registers and sweep state of the predictor.
    logic [RANGE_W-1:0] cfg_threshold = RANGE_W'(THRESH_RESET);
    logic [RANGE_W-1:0] cfg_near      = RANGE_W'(NEAR_RESET);
    logic               cfg_corr_on   = 1'b0;
    int                 cfg_corr      = 0;
    logic [RANGE_W-1:0] last_level;
    logic               obj_open;
    logic [ANGLE_W-1:0] obj_start;
    logic [DIST_W-1:0]  obj_sonar;
    logic [NUM_W-1:0]   obj_count;
    longint             tan_table [0:89];

    sample_t sample_feed [$];
    result_t expected_objects [$];
    int      queued_total = 0;
    int      gen_angle    = 0;
    int      error_count  = 0;

    // Driver, receiver and monitor bookkeeping.
    logic      in_taken    = 1'b0;
    logic      out_taken   = 1'b0;
    int        burst_left  = 0;
    int        gap_left    = 0;
    sample_t   next_item;
    int        hold_ticket = 0;
    int        hold_served = 0;
    int        hold_left   = 0;
    pop_mode_t pop_mode    = POP_ALWAYS;
    int        mode_left   = 0;
    int        idle_cycles = 0;
    logic      closed_now;
    result_t   rec_now;
    result_t   got;
    result_t   want;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic clear_sweep();
        last_level = RANGE_W'(PREV_RESET & LEVEL_MASK);
        obj_open   = 1'b0;
        obj_start  = '0;
        obj_sonar  = '0;
        obj_count  = '0;
    endtask

    function automatic longint tan_of_span(input int span);
        int     mag;
        int     r;
        longint v;
        mag = (span < 0) ? -span : span;
        r   = mag % 180;
        if (r == 90)
            return (span < 0) ? TAN_LO : TAN_HI;
        v = (r < 90) ? tan_table[r] : -tan_table[180 - r];
        return (span < 0) ? -v : v;
    endfunction

    // Classifies one accepted sample; closing an object yields its record.
    task automatic track_sample(input logic restart, input logic [ANGLE_W-1:0] angle_in,
                                input logic [RANGE_W-1:0] level_in,
                                input logic [DIST_W-1:0] sonar_in,
                                output logic closed, output result_t rec);
        logic [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0] level;
        logic [RANGE_W-1:0] diff;
        logic               jump;
        int                 span;
        longint             total;
        longint             w;
        closed = 1'b0;
        rec    = '0;
        if (restart)
            clear_sweep();
        angle = (angle_in > ANGLE_CAP) ? ANGLE_W'(ANGLE_CAP) : angle_in;
        level = level_in & RANGE_W'(LEVEL_MASK);
        diff  = (last_level >= level) ? last_level - level : level - last_level;
        jump  = (diff >= cfg_threshold);
        if (jump && !obj_open && level <= cfg_near)
        begin
            obj_open  = 1'b1;
            obj_start = angle;
            obj_sonar = sonar_in;
        end
        else if (jump && obj_open)
        begin
            span  = int'(angle) - int'(obj_start);
            total = longint'(obj_sonar) * tan_of_span(span)
                    * (64'sd1 <<< (16 - TAN_FRACTION_BITS));
            if (cfg_corr_on)
                total -= longint'(obj_sonar) * longint'(cfg_corr);
            // Arithmetic shift floors toward minus infinity, as the Q8 result needs.
            w = total >>> 8;
            if (w > WIDTH_HI)
                w = WIDTH_HI;
            if (w < WIDTH_LO)
                w = WIDTH_LO;
            rec.object_number   = obj_count;
            rec.center_angle    = ANGLE_W'((9'(obj_start) + 9'(angle)) >> 1);
            rec.object_distance = obj_sonar;
            rec.object_extent   = OBJW_W'(w);
            closed   = 1'b1;
            obj_open = 1'b0;
            if (obj_count != {NUM_W{1'b1}})
                obj_count++;
        end
        last_level = level;
    endtask

    // Writes a register with random bits above the register's own width.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        case (idx)
            REG_JUMP_THRESHOLD:
            begin
                data[RANGE_W-1:0] = RANGE_W'(value);
                cfg_threshold     = RANGE_W'(value);
            end
            REG_NEAR_LIMIT:
            begin
                data[RANGE_W-1:0] = RANGE_W'(value);
                cfg_near          = RANGE_W'(value);
            end
            REG_CORRECTION_ENABLED:
            begin
                data[0]     = value[0];
                cfg_corr_on = value[0];
            end
            REG_WIDTH_CORRECTION:
            begin
                data     = CFG_DATA_W'(value);
                cfg_corr = int'($signed(data));
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_sample(input logic restart, input logic [ANGLE_W-1:0] angle,
                                input logic [RANGE_W-1:0] level,
                                input logic [DIST_W-1:0] sonar);
        sample_t s;
        s.restart = restart;
        s.angle   = angle;
        s.level   = level;
        s.sonar   = sonar;
        sample_feed.push_back(s);
        queued_total++;
    endtask

    // One step of a sweep at the given level: the angle mostly advances,
    // sometimes jumps anywhere, and wraps around with a new sweep.
    task automatic queue_step(input int level);
        logic restart;
        int   sonar;
        restart = ($urandom_range(79, 0) == 0);
        gen_angle += $urandom_range(6, 0);
        if (gen_angle > 200)
        begin
            gen_angle = $urandom_range(20, 0);
            restart   = 1'b1;
        end
        if ($urandom_range(19, 0) == 0)
            gen_angle = $urandom_range(255, 0);
        case ($urandom_range(7, 0))
            0:       sonar = 0;
            1:       sonar = DIST_TOP;
            default: sonar = $urandom_range(DIST_TOP, 0);
        endcase
        queue_sample(restart, ANGLE_W'(gen_angle), RANGE_W'(level), DIST_W'(sonar));
    endtask

    function automatic int wobble(input int level, input int jit);
        int v;
        v = level + int'($urandom_range(2 * jit, 0)) - jit;
        if (v < 0)
            v = 0;
        if (v > RANGE_TOP)
            v = RANGE_TOP;
        return v;
    endfunction

    // Mostly well-formed objects (far floor, drop within the near limit, jump
    // back) with random content, the rest unstructured noise.
    task automatic queue_sweep(input int count);
        int stop_at;
        int lo_far;
        int far_lvl;
        int near_lvl;
        int jit;
        stop_at = queued_total + count;
        while (queued_total < stop_at)
        begin
            if ($urandom_range(9, 0) < 3)
            begin
                queue_sample(($urandom_range(9, 0) == 0), ANGLE_W'($urandom),
                             RANGE_W'($urandom), DIST_W'($urandom));
            end
            else
            begin
                lo_far = int'(cfg_near) + int'(cfg_threshold);
                if (lo_far > RANGE_TOP)
                    lo_far = RANGE_TOP;
                far_lvl  = $urandom_range(RANGE_TOP, lo_far);
                near_lvl = $urandom_range(int'(cfg_near), 0);
                jit      = ($urandom_range(1, 0) == 0) ? 0
                           : $urandom_range(int'(cfg_threshold) / 4, 0);
                repeat ($urandom_range(3, 1))
                    queue_step(wobble(far_lvl, jit));
                queue_step(near_lvl);
                repeat ($urandom_range(4, 0))
                    queue_step(wobble(near_lvl, jit));
                queue_step(far_lvl);
            end
        end
    endtask

    task automatic wait_idle();
        while (sample_feed.size() != 0 || push || expected_objects.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: bursts of requests separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (push && !in_taken)
            ;
        else if (gap_left > 0)
        begin
            gap_left--;
            push <= 1'b0;
        end
        else if (sample_feed.size() != 0)
        begin
            next_item = sample_feed.pop_front();
            first_of_sweep <= next_item.restart;
            sweep_angle    <= next_item.angle;
            range_sample   <= next_item.level;
            sonar_distance <= next_item.sonar;
            push           <= 1'b1;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(20, 1);
                gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(24, 1);
            end
        end
        else
            push <= 1'b0;
    end

    // Receiver: changing pop patterns, plus a long hold when one is requested.
    always @(negedge clk)
    begin
        if (hold_served != hold_ticket)
        begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                pop_mode  = pop_mode_t'($urandom_range(3, 0));
                mode_left = $urandom_range(64, 8);
            end
            mode_left--;
            case (pop_mode)
                POP_ALWAYS:  pop <= 1'b1;
                POP_COIN:    pop <= 1'($urandom_range(1, 0));
                POP_TRICKLE: pop <= ($urandom_range(3, 0) == 0);
                default:     pop <= 1'b0;
            endcase
        end
    end

    // Monitor: predicts on each accepted request, checks each accepted record.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken  = push && !full;
            out_taken = pop && !empty;
            if (in_taken)
            begin
                track_sample(first_of_sweep, sweep_angle, range_sample, sonar_distance,
                             closed_now, rec_now);
                if (closed_now)
                    expected_objects.push_back(rec_now);
            end
            if (out_taken)
            begin
                got = {object_number, center_angle, object_distance, object_extent};
                if (expected_objects.size() == 0)
                    report_mismatch($sformatf("record %0d with no object predicted",
                                              got.object_number));
                else
                begin
                    want = expected_objects.pop_front();
                    if (got.object_number !== want.object_number)
                        report_mismatch($sformatf("object_number %0d, predicted %0d",
                                                  got.object_number, want.object_number));
                    if (got.center_angle !== want.center_angle)
                        report_mismatch($sformatf("center_angle %0d, predicted %0d",
                                                  got.center_angle, want.center_angle));
                    if (got.object_distance !== want.object_distance)
                        report_mismatch($sformatf("object_distance %0d, predicted %0d",
                                                  got.object_distance, want.object_distance));
                    if (got.object_extent !== want.object_extent)
                        report_mismatch($sformatf("object_extent %0d, predicted %0d",
                                                  got.object_extent, want.object_extent));
                end
            end
            if (in_taken || out_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] timeout: nothing accepted for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        longint unsigned s_q;
        longint unsigned c_q;
        longint unsigned ns_q;
        longint unsigned nc_q;
        longint unsigned t_q;
        // Tangent table: rotate (cos, sin) in Q30 by one degree per entry.
        s_q = 0;
        c_q = 64'd1 << 30;
        for (int k = 0; k < 90; k++)
        begin
            t_q = ((s_q << TAN_FRACTION_BITS) + c_q / 2) / c_q;
            tan_table[k] = (t_q > TAN_HI) ? TAN_HI : longint'(t_q);
            ns_q = (s_q * COS_ONE_DEG + c_q * SIN_ONE_DEG + (64'd1 << 29)) >> 30;
            nc_q = (c_q * COS_ONE_DEG - s_q * SIN_ONE_DEG + (64'd1 << 29)) >> 30;
            s_q = ns_q;
            c_q = nc_q;
        end
        clear_sweep();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed samples under the reset settings.
        queue_sample(1'b1, 8'd0, 12'd0, 10'd1023);      // opens at 0 with full distance
        queue_sample(1'b0, 8'd90, 12'd300, 10'd5);      // right angle, tangent saturates high
        queue_sample(1'b0, 8'd100, 12'd0, 10'd500);
        queue_sample(1'b0, 8'd10, 12'd4095, 10'd0);     // minus a right angle, saturates low
        queue_sample(1'b0, 8'd20, 12'd4000, 10'd7);     // change just below the threshold
        queue_sample(1'b0, 8'd30, 12'd200, 10'd9);      // edge, but beyond the near limit
        queue_sample(1'b0, 8'd40, 12'd20, 10'd600);
        queue_sample(1'b0, 8'd255, 12'd1000, 10'd1);    // angle clamps; span above 90
        queue_sample(1'b0, 8'd0, 12'd0, 10'd1023);
        queue_sample(1'b0, 8'd200, 12'd2048, 10'd0);    // span of 180 gives zero width
        queue_sample(1'b0, 8'd170, 12'd100, 10'd333);
        queue_sample(1'b1, 8'd5, 12'hAAA, 10'h2AA);     // new sweep drops the open object
        queue_sample(1'b0, 8'd6, 12'h555, 10'h155);
        queue_sample(1'b0, 8'd7, 12'd0, 10'd1023);
        queue_sample(1'b0, 8'd96, 12'd4095, 10'd1023);  // largest table entry
        queue_sample(1'b0, 8'd180, 12'd100, 10'd2);
        queue_sample(1'b0, 8'd0, 12'd3000, 10'd3);      // stop below start, span -180
        queue_sample(1'b0, 8'd90, 12'd0, 10'd1023);
        queue_sample(1'b0, 8'd0, 12'd500, 10'd4);
        queue_sample(1'b1, 8'd0, 12'd300, 10'd0);       // no change from the reset sample
        wait_idle();

        // Correction at both extremes drives the width into saturation.
        write_reg(REG_CORRECTION_ENABLED, 1);
        write_reg(REG_WIDTH_CORRECTION, -131072);
        queue_sample(1'b0, 8'd0, 12'd0, 10'd1023);
        queue_sample(1'b0, 8'd90, 12'd300, 10'd0);
        wait_idle();
        write_reg(REG_WIDTH_CORRECTION, 131071);
        queue_sample(1'b0, 8'd90, 12'd0, 10'd1023);
        queue_sample(1'b0, 8'd0, 12'd300, 10'd0);
        queue_sweep(30);
        wait_idle();

        // Every sample is an edge, so objects alternate open and close while
        // the receiver holds off and the block fills up.
        write_reg(REG_JUMP_THRESHOLD, 0);
        write_reg(REG_NEAR_LIMIT, RANGE_TOP);
        write_reg(REG_CORRECTION_ENABLED, 0);
        hold_ticket++;
        queue_sample(1'b1, ANGLE_W'($urandom), RANGE_W'($urandom), DIST_W'($urandom));
        repeat (199)
            queue_sample(1'b0, ANGLE_W'($urandom), RANGE_W'($urandom), DIST_W'($urandom));
        wait_idle();

        // Only a full-scale swing is an edge, and only a zero sample opens.
        write_reg(REG_JUMP_THRESHOLD, RANGE_TOP);
        write_reg(REG_NEAR_LIMIT, 0);
        write_reg(REG_CORRECTION_ENABLED, 1);
        write_reg(REG_WIDTH_CORRECTION, int'($urandom_range(262143, 0)) - 131072);
        queue_sweep(30);
        wait_idle();

        repeat (3)
        begin
            write_reg(REG_JUMP_THRESHOLD, $urandom_range(600, 1));
            write_reg(REG_NEAR_LIMIT, $urandom_range(3000, 50));
            write_reg(REG_CORRECTION_ENABLED, $urandom_range(1, 0));
            write_reg(REG_WIDTH_CORRECTION, int'($urandom_range(262143, 0)) - 131072);
            queue_sweep(45);
            wait_idle();
        end

        if (!empty)
            report_mismatch("record left in the block with no object predicted");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
